[hdl/lmf_pkg.sv]
// Shared types and constants of the log-mel feature frontend.
// Holds the request and result structs and the divider handshake structs.
// No dependencies.
package lmf_pkg;

  localparam int FFT_SIZE_DEF  = 1024;
  localparam int MEL_BANDS_DEF = 128;

  localparam int ACC_W   = 58;
  localparam int FLOOR_W = 16;
  localparam int DIV_W   = 50;
  localparam int DEN_W   = 32;

  localparam logic [1:0] CMD_BIN       = 2'd0;
  localparam logic [1:0] CMD_LOAD_WT   = 2'd1;
  localparam logic [1:0] CMD_LOAD_NORM = 2'd2;
  localparam logic [1:0] CMD_READ      = 2'd3;

  localparam logic KIND_BIN  = 1'b0;
  localparam logic KIND_BAND = 1'b1;

  localparam logic [31:0]      LN2_Q32   = 32'd2977044472;
  localparam logic [30:0]      SCALE_ONE = 31'd65536;
  localparam logic [ACC_W-1:0] ACC_MAX   = '1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         slot;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;
    logic [6:0]         first_band;
    logic [6:0]         second_band;
    logic [23:0]        first_weight;
    logic [23:0]        second_weight;
    logic signed [31:0] band_mean;
    logic [30:0]        band_scale;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        magnitude;
    logic signed [15:0] unit_cos;
    logic signed [15:0] unit_sin;
    logic signed [31:0] band_value;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/lmf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lmf_pkg for the request and response structs.
module lmf_div (
  input  logic             clk,
  input  logic             rst_n,
  input  lmf_pkg::div_req_t req,
  output lmf_pkg::div_rsp_t rsp
);
  import lmf_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    fits     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        den_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_W-2:0], fits};
        rem_r <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[hdl/log_mel_feature_frontend.sv]
// Bin magnitude and unit phase, mel-band scatter accumulation and normalized log readout.
// A bin sample runs the 32-step square root and, for a nonzero magnitude, two phase
// divisions on the shared bit-serial divider; a band read in range runs the normalize search, 24
// squarings and one division. Table loads complete at the accepting edge and leave busy
// low. One item is worked on at a time; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears accumulators and norm table through valid bits at once.
module log_mel_feature_frontend #(
  parameter int FFT_SIZE  = lmf_pkg::FFT_SIZE_DEF,
  parameter int MEL_BANDS = lmf_pkg::MEL_BANDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lmf_pkg::in_item_t in_data,
  output logic              out_valid,
  output lmf_pkg::out_item_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lmf_pkg::*;

  localparam int BIN_COUNT = FFT_SIZE / 2 + 1;
  localparam int BIN_AW    = $clog2(BIN_COUNT);
  localparam int BAND_AW   = (MEL_BANDS > 1) ? $clog2(MEL_BANDS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_RE, S_SQ_IM, S_SUM, S_SQRT, S_SQRT_FIN, S_COS, S_COS_WAIT, S_SIN,
    S_SIN_WAIT, S_ACC_RD, S_ACC_MUL, S_ACC_WR, S_LG_INIT, S_LG_NORM, S_LG_SQ,
    S_LG_MUL, S_LG_RND, S_DIFF, S_BV, S_BV_WAIT, S_OUT
  } state_t;

  state_t state_r;

  // Configuration register.
  logic [FLOOR_W-1:0] floor_r;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 3'd0);
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {16'd0, floor_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= FLOOR_W'(1);
    end else if (cfg_wr) begin
      floor_r <= pwdata[FLOOR_W-1:0];
    end
  end

  logic accept;
  assign accept = start && !busy;

  logic [15:0] slot_ext;
  logic        slot_bin_ok;
  logic        slot_band_ok;
  assign slot_ext     = {6'd0, in_data.slot};
  assign slot_bin_ok  = slot_ext < 16'(BIN_COUNT);
  assign slot_band_ok = slot_ext < 16'(MEL_BANDS);

  // Memories.
  logic [61:0] wtab_mem [0:BIN_COUNT-1];
  logic [62:0] norm_mem [0:MEL_BANDS-1];
  logic [ACC_W-1:0] acc_mem [0:MEL_BANDS-1];

  logic [61:0]      wt_q_r;
  logic [62:0]      norm_q_r;
  logic [ACC_W-1:0] acc_q_r;

  logic [BIN_AW-1:0]  wt_addr;
  logic [BAND_AW-1:0] slot_band;
  logic [BAND_AW-1:0] acc_addr;
  logic               acc_rd_en;
  logic               acc_wr_en;
  logic [ACC_W-1:0]   acc_wdata;

  assign wt_addr   = slot_ext[BIN_AW-1:0];
  assign slot_band = slot_ext[BAND_AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == CMD_LOAD_WT && slot_bin_ok) begin
      wtab_mem[wt_addr] <= {in_data.second_weight, in_data.first_weight,
                            in_data.second_band, in_data.first_band};
    end
    if (accept && in_data.cmd == CMD_BIN) begin
      wt_q_r <= wtab_mem[wt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == CMD_LOAD_NORM && slot_band_ok) begin
      norm_mem[slot_band] <= {in_data.band_mean, in_data.band_scale};
    end
    if (accept && in_data.cmd == CMD_READ) begin
      norm_q_r <= norm_mem[slot_band];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_wr_en) begin
      acc_mem[acc_addr] <= acc_wdata;
    end
    if (acc_rd_en) begin
      acc_q_r <= acc_mem[acc_addr];
    end
  end

  // Working registers.
  in_item_t           in_r;
  logic               bin_ok_r;
  logic               kind_r;
  logic [31:0]        magn_r;
  logic signed [15:0] cos_r;
  logic signed [15:0] sin_r;
  logic signed [31:0] bv_r;
  logic [63:0]        sq_a_r;
  logic [63:0]        sq_b_r;
  logic [63:0]        rad_r;
  logic [33:0]        srem_r;
  logic [31:0]        root_r;
  logic [5:0]         cnt_r;
  logic               sel_r;
  logic [48:0]        share_r;
  logic [MEL_BANDS-1:0] accv_r;
  logic [MEL_BANDS-1:0] normv_r;
  logic               accv_q_r;
  logic               normv_q_r;
  logic [58:0]        lm_r;
  logic [5:0]         e_r;
  logic [30:0]        m_r;
  logic [23:0]        frac_r;
  logic signed [63:0] prod_r;
  logic signed [24:0] ln_r;
  logic signed [33:0] diff_r;
  logic signed [31:0] mean_r;
  logic [30:0]        sc_r;

  // Magnitudes of the bin parts.
  logic [31:0] ar;
  logic [31:0] ai;
  assign ar = in_r.real_part[31] ? 32'(-in_r.real_part) : 32'(in_r.real_part);
  assign ai = in_r.imag_part[31] ? 32'(-in_r.imag_part) : 32'(in_r.imag_part);

  // Square root step, two radicand bits per cycle.
  logic [35:0] srem_sh;
  logic [35:0] trial;
  logic        s_ge;
  assign srem_sh = {srem_r, rad_r[63:62]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign s_ge    = srem_sh >= trial;

  // Accumulation path.
  logic [6:0]   band_cur;
  logic [23:0]  w_cur;
  logic         band_ok;
  logic [7:0]   band_ext;
  logic [58:0]  acc_sum;
  assign band_cur = sel_r ? wt_q_r[13:7] : wt_q_r[6:0];
  assign w_cur    = sel_r ? wt_q_r[61:38] : wt_q_r[37:14];
  assign band_ext = {1'b0, band_cur};
  assign band_ok  = 9'({1'b0, band_ext}) < 9'(MEL_BANDS);
  assign acc_sum  = 59'(accv_q_r ? acc_q_r : '0) + 59'(share_r);
  assign acc_wdata = acc_sum[58] ? ACC_MAX : acc_sum[ACC_W-1:0];

  always_comb begin
    acc_addr  = (state_r == S_IDLE) ? slot_band : band_ext[BAND_AW-1:0];
    acc_rd_en = (accept && in_data.cmd == CMD_READ) || (state_r == S_ACC_RD && band_ok);
    acc_wr_en = (state_r == S_ACC_WR);
  end

  // Log path.
  logic [58:0] x_sum;
  logic [61:0] mm;
  logic [31:0] sq_t;
  logic [6:0]  e_m16;
  logic [63:0] prod_mag;
  logic [23:0] ln_mag;
  logic [33:0] diff_mag;
  assign x_sum    = 59'(accv_q_r ? acc_q_r : '0) + 59'(floor_r);
  assign mm       = 62'(m_r) * 62'(m_r);
  assign sq_t     = mm[61:30];
  assign e_m16    = 7'({1'b0, e_r}) - 7'd16;
  assign prod_mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign ln_mag   = 24'((prod_mag + 64'(1) * (64'd1 << 39)) >> 40);
  assign diff_mag = diff_r[33] ? 34'(-diff_r) : 34'(diff_r);

  // Shared divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  lmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = magn_r;
    unique case (state_r)
      S_COS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({ar, 15'd0}) + DIV_W'(magn_r[31:1]);
      end
      S_SIN: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({ai, 15'd0}) + DIV_W'(magn_r[31:1]);
      end
      S_BV: begin
        div_req.start    = 1'b1;
        div_req.divisor  = DEN_W'(sc_r);
        div_req.dividend = DIV_W'({diff_mag, 16'd0}) + DIV_W'(sc_r[30:1]);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  function automatic logic signed [15:0] trig_clamp(input logic [DIV_W-1:0] q,
                                                     input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (q >= DIV_W'(32768)) ? 16'sh8000 : 16'(~q[15:0] + 16'd1);
    end else begin
      r = (q >= DIV_W'(32768)) ? 16'sh7FFF : 16'(q[15:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] band_clamp(input logic [DIV_W-1:0] q,
                                                     input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (q >= (DIV_W'(1) << 31)) ? 32'sh80000000 : 32'(~q[31:0] + 32'd1);
    end else begin
      r = (q >= (DIV_W'(1) << 31)) ? 32'sh7FFFFFFF : 32'(q[31:0]);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      accv_r  <= '0;
      normv_r <= '0;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            in_r     <= in_data;
            bin_ok_r <= slot_bin_ok;
            magn_r   <= '0;
            cos_r    <= '0;
            sin_r    <= '0;
            bv_r     <= '0;
            sel_r    <= 1'b0;
            unique case (in_data.cmd)
              CMD_BIN: begin
                kind_r  <= KIND_BIN;
                state_r <= S_SQ_RE;
                // Bin 0 starts a new frame.
                if (in_data.slot == 10'd0) begin
                  accv_r <= '0;
                end
              end
              CMD_LOAD_WT: begin
                state_r <= S_IDLE;
              end
              CMD_LOAD_NORM: begin
                if (slot_band_ok) begin
                  normv_r[slot_band] <= 1'b1;
                end
              end
              CMD_READ: begin
                kind_r <= KIND_BAND;
                if (slot_band_ok) begin
                  accv_q_r  <= accv_r[slot_band];
                  normv_q_r <= normv_r[slot_band];
                  state_r   <= S_LG_INIT;
                end else begin
                  state_r <= S_OUT;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SQ_RE: begin
          sq_a_r  <= 64'(ar) * 64'(ar);
          state_r <= S_SQ_IM;
        end
        S_SQ_IM: begin
          sq_b_r  <= 64'(ai) * 64'(ai);
          state_r <= S_SUM;
        end
        S_SUM: begin
          rad_r   <= sq_a_r + sq_b_r;
          srem_r  <= '0;
          root_r  <= '0;
          cnt_r   <= 6'd32;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          srem_r <= s_ge ? 34'(srem_sh - trial) : srem_sh[33:0];
          root_r <= {root_r[30:0], s_ge};
          rad_r  <= {rad_r[61:0], 2'b00};
          cnt_r  <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= S_SQRT_FIN;
          end
        end
        S_SQRT_FIN: begin
          // Round half up: the remainder exceeds the root exactly when sqrt >= root + 1/2.
          magn_r  <= (srem_r > {2'b00, root_r}) ? root_r + 32'd1 : root_r;
          state_r <= S_COS;
        end
        S_COS: begin
          if (magn_r == 32'd0) begin
            state_r <= bin_ok_r ? S_ACC_RD : S_OUT;
          end else begin
            state_r <= S_COS_WAIT;
          end
        end
        S_COS_WAIT: begin
          if (div_rsp.done) begin
            cos_r   <= trig_clamp(div_rsp.quotient, in_r.real_part[31]);
            state_r <= S_SIN;
          end
        end
        S_SIN: begin
          state_r <= S_SIN_WAIT;
        end
        S_SIN_WAIT: begin
          if (div_rsp.done) begin
            sin_r   <= trig_clamp(div_rsp.quotient, in_r.imag_part[31]);
            state_r <= bin_ok_r ? S_ACC_RD : S_OUT;
          end
        end
        S_ACC_RD: begin
          if (band_ok) begin
            accv_q_r <= accv_r[band_ext[BAND_AW-1:0]];
            state_r  <= S_ACC_MUL;
          end else if (!sel_r) begin
            sel_r <= 1'b1;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_ACC_MUL: begin
          share_r <= 49'((57'(56'(magn_r) * 56'(w_cur)) + 57'd128) >> 8);
          state_r <= S_ACC_WR;
        end
        S_ACC_WR: begin
          accv_r[band_ext[BAND_AW-1:0]] <= 1'b1;
          if (!sel_r) begin
            sel_r   <= 1'b1;
            state_r <= S_ACC_RD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_LG_INIT: begin
          lm_r    <= (x_sum == 59'd0) ? 59'd1 : x_sum;
          e_r     <= 6'd58;
          mean_r  <= normv_q_r ? norm_q_r[62:31] : 32'sd0;
          sc_r    <= (!normv_q_r || norm_q_r[30:0] == 31'd0) ? SCALE_ONE : norm_q_r[30:0];
          state_r <= S_LG_NORM;
        end
        S_LG_NORM: begin
          if (lm_r[58] || e_r == 6'd0) begin
            m_r     <= lm_r[58:28];
            frac_r  <= '0;
            cnt_r   <= 6'd24;
            state_r <= S_LG_SQ;
          end else begin
            lm_r <= {lm_r[57:0], 1'b0};
            e_r  <= e_r - 6'd1;
          end
        end
        S_LG_SQ: begin
          // Squaring doubles log2 of the mantissa; overflow past 2.0 yields the next bit.
          frac_r <= {frac_r[22:0], sq_t[31]};
          m_r    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
          cnt_r  <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= S_LG_MUL;
          end
        end
        S_LG_MUL: begin
          prod_r  <= 64'($signed({e_m16, frac_r})) * 64'($signed({1'b0, LN2_Q32}));
          state_r <= S_LG_RND;
        end
        S_LG_RND: begin
          ln_r    <= prod_r[63] ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          diff_r  <= 34'(ln_r) - 34'(mean_r);
          state_r <= S_BV;
        end
        S_BV: begin
          state_r <= S_BV_WAIT;
        end
        S_BV_WAIT: begin
          if (div_rsp.done) begin
            bv_r    <= band_clamp(div_rsp.quotient, diff_r[33]);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_data.kind       = kind_r;
    out_data.magnitude  = magn_r;
    out_data.unit_cos   = cos_r;
    out_data.unit_sin   = sin_r;
    out_data.band_value = bv_r;
  end

endmodule

[hdl/lmf_chk.sv]
// Port-level checks for the log-mel feature frontend, attached by bind.
// Depends on lmf_pkg for the request and result structs.
module lmf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input lmf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input lmf_pkg::out_item_t out_data,
  input logic               psel,
  input logic               penable,
  input logic               pready
);
  import lmf_pkg::*;

  // A result only appears while a request is in flight.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe without a request in flight");

  // A bin sample or band read keeps the block busy in the next cycle.
  a_work_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.cmd == CMD_BIN || in_data.cmd == CMD_READ)) |=> busy)
    else $error("work request did not raise busy");

  // Each result is a one-cycle strobe.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A zero bin has zero unit phase.
  a_zero_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_BIN && out_data.magnitude == 32'd0) |->
      (out_data.unit_cos == 16'sd0 && out_data.unit_sin == 16'sd0))
    else $error("nonzero unit phase on a zero magnitude");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable) |-> pready)
    else $error("configuration access stalled");

endmodule

bind log_mel_feature_frontend lmf_chk u_lmf_chk (.*);

[test/tb_log_mel_feature_frontend.sv]
// Self-checking testbench of log_mel_feature_frontend: bin magnitude and phase,
// mel-band accumulation and normalized log readout against an in-bench predictor.
// Depends on lmf_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_log_mel_feature_frontend;
  import lmf_pkg::*;

  localparam int BINS   = FFT_SIZE_DEF / 2 + 1;
  localparam int BANDS  = MEL_BANDS_DEF;
  localparam int SETTLE = 200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] ADDR_LOG_FLOOR = 3'd0;

  logic clk, rst_n, start, busy, out_valid;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  log_mel_feature_frontend dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic [6:0]          wt_band_a [BINS];
  logic [6:0]          wt_band_b [BINS];
  logic [23:0]         wt_a [BINS];
  logic [23:0]         wt_b [BINS];
  longint              norm_mean [BANDS];
  longint unsigned     norm_scale [BANDS];
  longint unsigned     mel_acc [BANDS];
  longint unsigned     floor_value;

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  bit        weights_loaded[BINS];
  bit        no_idle;
  int        gap_left, errors, bins_checked, bands_checked, requests_sent, idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned sqrt_rounded(longint unsigned s);
    longint unsigned rem, r, b;
    rem = s; r = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return (rem > r) ? r + 1 : r;
  endfunction

  function automatic longint quotient_rounded(longint num, longint unsigned den);
    longint unsigned a, q;
    a = (num < 0) ? longint'(-num) : num;
    q = (a + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void add_to_band(logic [6:0] band, longint unsigned magn, logic [23:0] w);
    longint unsigned sum;
    if (band >= BANDS) return;
    sum = mel_acc[band] + ((magn * w + 128) >> 8);
    mel_acc[band] = (sum > ACC_MAX) ? ACC_MAX : sum;
  endfunction

  // Natural log of x / 2^16 in Q.16 by repeated squaring of the mantissa.
  function automatic longint natural_log_q16(longint unsigned x);
    int e;
    longint unsigned m, frac, r;
    longint lg, prod;
    e = 63; frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    m = (e <= 30) ? x << (30 - e) : x >> (e - 30);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        frac |= 64'd1 << (23 - i);
        m >>= 1;
      end
    end
    lg = (longint'(e) - 16) * 16777216 + longint'(frac);
    prod = lg * longint'(LN2_Q32);
    r = (((prod < 0) ? longint'(-prod) : prod) + (64'd1 << 39)) >> 40;
    return (prod < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void predict_request(in_item_t req);
    out_item_t res;
    longint re, im, c, s, diff;
    longint unsigned magn, x, sc;
    res = '0;
    case (req.cmd)
      CMD_BIN: begin
        re = req.real_part; im = req.imag_part;
        magn = sqrt_rounded(longint'(re * re) + longint'(im * im));
        c = 0; s = 0;
        if (magn != 0) begin
          c = clip(quotient_rounded(re * 32768, magn), -32768, 32767);
          s = clip(quotient_rounded(im * 32768, magn), -32768, 32767);
        end
        if (req.slot < BINS) begin
          if (req.slot == 0) foreach (mel_acc[i]) mel_acc[i] = 0;
          add_to_band(wt_band_a[req.slot], magn, wt_a[req.slot]);
          add_to_band(wt_band_b[req.slot], magn, wt_b[req.slot]);
        end
        res.kind = KIND_BIN;
        res.magnitude = magn[31:0];
        res.unit_cos = c[15:0];
        res.unit_sin = s[15:0];
        expected_results.push_back(res);
      end
      CMD_LOAD_WT: begin
        if (req.slot < BINS) begin
          wt_band_a[req.slot] = req.first_band;
          wt_band_b[req.slot] = req.second_band;
          wt_a[req.slot] = req.first_weight;
          wt_b[req.slot] = req.second_weight;
        end
      end
      CMD_LOAD_NORM: begin
        if (req.slot < BANDS) begin
          norm_mean[req.slot] = req.band_mean;
          norm_scale[req.slot] = req.band_scale;
        end
      end
      default: begin
        res.kind = KIND_BAND;
        if (req.slot < BANDS) begin
          x = mel_acc[req.slot] + floor_value;
          if (x == 0) x = 1;
          sc = (norm_scale[req.slot] == 0) ? 64'd65536 : norm_scale[req.slot];
          diff = natural_log_q16(x) - norm_mean[req.slot];
          c = clip(quotient_rounded(diff * 65536, sc), -64'sd2147483648, 64'sd2147483647);
          res.band_value = c[31:0];
        end
        expected_results.push_back(res);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sender: holds a request until accepted, then pauses for a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_request(in_data);
        requests_sent++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        start <= 1'b1;
        if (no_idle) gap_left <= 0;
        else if ($urandom_range(0, 19) == 0) gap_left <= $urandom_range(10, 60);
        else gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        out_item_t want;
        want = expected_results.pop_front();
        if (out_data.kind != want.kind) report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.magnitude != want.magnitude)
          report_mismatch("magnitude", out_data.magnitude, want.magnitude);
        if (out_data.unit_cos != want.unit_cos)
          report_mismatch("unit_cos", out_data.unit_cos, want.unit_cos);
        if (out_data.unit_sin != want.unit_sin)
          report_mismatch("unit_sin", out_data.unit_sin, want.unit_sin);
        if (out_data.band_value != want.band_value)
          report_mismatch("band_value", out_data.band_value, want.band_value);
        if (want.kind == KIND_BIN) bins_checked++;
        else bands_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t base_request(logic [1:0] cmd, int slot);
    in_item_t r;
    r = '0;
    r.cmd = cmd;
    r.slot = 10'(slot);
    // Fields the command does not use carry noise.
    r.real_part = $urandom; r.imag_part = $urandom;
    r.band_mean = $urandom; r.band_scale = 31'($urandom);
    r.first_band = 7'($urandom); r.second_band = 7'($urandom);
    r.first_weight = 24'($urandom); r.second_weight = 24'($urandom);
    return r;
  endfunction

  task automatic queue_bin(int slot, logic [31:0] re, logic [31:0] im);
    in_item_t r;
    r = base_request(CMD_BIN, slot);
    r.real_part = re; r.imag_part = im;
    pending_requests.push_back(r);
  endtask

  task automatic queue_weights(int slot, int ba, int bb, int wa, int wb);
    in_item_t r;
    r = base_request(CMD_LOAD_WT, slot);
    r.first_band = 7'(ba); r.second_band = 7'(bb);
    r.first_weight = 24'(wa); r.second_weight = 24'(wb);
    pending_requests.push_back(r);
    if (slot < BINS) weights_loaded[slot] = 1'b1;
  endtask

  task automatic queue_norm(int slot, logic [31:0] mean, int scale);
    in_item_t r;
    r = base_request(CMD_LOAD_NORM, slot);
    r.band_mean = mean; r.band_scale = 31'(scale);
    pending_requests.push_back(r);
  endtask

  task automatic queue_read(int slot);
    pending_requests.push_back(base_request(CMD_READ, slot));
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_log_floor(logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_LOG_FLOOR; pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    floor_value = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // One frame: bin 0 clears the bands, then loaded bins feed them, then some bands are read.
  task automatic queue_frame();
    int nbins;
    int s;
    if ($urandom_range(0, 3) == 0)
      queue_weights($urandom_range(0, 40), $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 5) == 0) queue_norm($urandom_range(0, 1023), pick_word(), $urandom);
    queue_bin(0, pick_word(), pick_word());
    nbins = $urandom_range(1, 6);
    for (int i = 0; i < nbins; i++) begin
      if ($urandom_range(0, 7) == 0) s = $urandom_range(BINS, 1023);
      else begin
        do s = ($urandom_range(0, 9) == 0) ? BINS - 1 : $urandom_range(0, 40);
        while (!weights_loaded[s]);
      end
      queue_bin(s, pick_word(), pick_word());
    end
    for (int i = 0; i < $urandom_range(1, 3); i++)
      queue_read(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 127));
  endtask

  initial begin
    logic [15:0] floors[4];
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; bins_checked = 0; bands_checked = 0; requests_sent = 0; idle_cycles = 0;
    no_idle = 1'b0; floor_value = 1;
    foreach (norm_mean[i]) begin
      norm_mean[i] = 0; norm_scale[i] = 65536; mel_acc[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners.
    queue_read(5);
    queue_read(1023);
    queue_weights(0, 3, 127, 'hffffff, 'hffffff);
    queue_weights(BINS - 1, 0, 64, 'h800000, 0);
    queue_weights(600, 1, 2, 1, 1);
    queue_bin(0, 32'h8000_0000, 32'h8000_0000);
    queue_bin(BINS - 1, 32'h7fff_ffff, 32'd0);
    queue_bin(0, 32'd0, 32'd0);
    queue_bin(0, 32'd0, 32'hffff_ffff);
    queue_bin(1023, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_bin(BINS, 32'd3, 32'hffff_fffc);
    queue_bin(0, 32'h7fff_ffff, 32'h8000_0000);
    queue_norm(3, 32'h7fff_ffff, 0);
    queue_norm(200, 32'h8000_0000, 1);
    queue_norm(127, 32'h8000_0000, 1);
    queue_norm(4, 32'h0001_0000, 'h7fffffff);
    queue_read(3);
    queue_read(127);
    queue_read(4);
    queue_read(0);
    queue_read(128);
    wait_until_drained();

    // A zero floor with empty bands takes the log of one LSB.
    write_log_floor(16'd0);
    queue_bin(0, 32'd0, 32'd0);
    queue_read(3);
    queue_read(50);
    wait_until_drained();

    floors[0] = 16'hffff; floors[1] = 16'd1; floors[2] = 16'($urandom); floors[3] = 16'd0;
    for (int i = 0; i < BINS; i += 37)
      queue_weights(i, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i <= 40; i++)
      queue_weights(i, $urandom, $urandom, ($urandom_range(0, 4) == 0) ? 0 : $urandom,
                    $urandom);
    for (int p = 0; p < 4; p++) begin
      write_log_floor(floors[p]);
      no_idle = (p == 2);
      while (pending_requests.size() < 80) queue_frame();
      wait_until_drained();
    end

    $display("Checked %0d bin results and %0d band results from %0d requests,",
             bins_checked, bands_checked, requests_sent);
    $display("across four log floor settings including zero and full scale.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[log_mel_feature_frontend.f]
hdl/lmf_pkg.sv
hdl/lmf_div.sv
hdl/log_mel_feature_frontend.sv
hdl/lmf_chk.sv
test/tb_log_mel_feature_frontend.sv
